// ===== hw/rtl/gpio_pin_register_block_unit_defines.svh =====
// ----------------------------------------------------------------------------
// GPIO pin register block - assertion macros
// Clocked assertion helpers shared by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef GPIO_PIN_REGISTER_BLOCK_UNIT_DEFINES_SVH
`define GPIO_PIN_REGISTER_BLOCK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// prop must hold at every rising edge outside reset
`define GPRB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// cond must never be true at a rising edge outside reset
`define GPRB_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define GPRB_ASSERT(label, clk, rst_n, prop)
`define GPRB_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/gprb_pkg.sv =====
// ----------------------------------------------------------------------------
// GPIO pin register block - package
// Transfer payload types, word offsets and field constants.
// ----------------------------------------------------------------------------
package gprb_pkg;

    localparam int DATA_W        = 32;
    localparam int PORT_PINS     = 28;
    localparam int FSEL_WORDS    = 3;
    localparam int PINS_PER_WORD = 10;
    localparam int FSEL_BITS     = 3;
    localparam int FSEL_WIDTH    = PINS_PER_WORD * FSEL_BITS;

    // access kind
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // word offsets
    localparam logic [3:0] WORD_FSEL0 = 4'd0;
    localparam logic [3:0] WORD_FSEL1 = 4'd1;
    localparam logic [3:0] WORD_FSEL2 = 4'd2;
    localparam logic [3:0] WORD_SET   = 4'd7;
    localparam logic [3:0] WORD_CLEAR = 4'd10;
    localparam logic [3:0] WORD_LEVEL = 4'd13;

    // function select codes
    localparam logic [FSEL_BITS-1:0] CODE_INPUT  = 3'b000;
    localparam logic [FSEL_BITS-1:0] CODE_OUTPUT = 3'b001;

    typedef struct packed {
        logic                 action;
        logic [3:0]           word_index;
        logic [DATA_W-1:0]    write_data;
        logic [PORT_PINS-1:0] pin_inputs;
    } gprb_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]    read_data;
        logic [PORT_PINS-1:0] pin_drive;
        logic [PORT_PINS-1:0] pin_output_enable;
    } gprb_rsp_t;

endpackage

// ===== hw/rtl/gprb_regfile.sv =====
// ----------------------------------------------------------------------------
// GPIO pin register block - register file
// Function select words and output latch, with the access decode.
// ----------------------------------------------------------------------------
module gprb_regfile #(
    parameter int PIN_COUNT = 28
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  gprb_pkg::gprb_req_t req,
    output gprb_pkg::gprb_rsp_t rsp
);
    import gprb_pkg::*;

    logic [FSEL_WORDS-1:0][FSEL_WIDTH-1:0] fsel_reg, fsel_next;
    logic [PIN_COUNT-1:0]                  latch_reg, latch_next;
    logic [PIN_COUNT-1:0]                  oe_now, oe_next, level;
    logic [PIN_COUNT-1:0]                  ext;
    logic [PIN_COUNT-1:0]                  wdata;
    logic [DATA_W-1:0]                     ext32, latch32, oe32, rdata;

    // stored bits of a function select word: fields of existing pins only
    function automatic logic [FSEL_WIDTH-1:0] fsel_mask(input int w);
        logic [FSEL_WIDTH-1:0] m;
        m = '0;
        for (int k = 0; k < PINS_PER_WORD; k++) begin
            if (w * PINS_PER_WORD + k < PIN_COUNT) begin
                m[k*FSEL_BITS +: FSEL_BITS] = '1;
            end
        end
        return m;
    endfunction

    function automatic logic [PIN_COUNT-1:0] enables(
        input logic [FSEL_WORDS-1:0][FSEL_WIDTH-1:0] f
    );
        logic [DATA_W-1:0] o;
        o = '0;
        for (int w = 0; w < FSEL_WORDS; w++) begin
            for (int k = 0; k < PINS_PER_WORD; k++) begin
                if (f[w][k*FSEL_BITS +: FSEL_BITS] == CODE_OUTPUT) begin
                    o[w*PINS_PER_WORD + k] = 1'b1;
                end
            end
        end
        return o[PIN_COUNT-1:0];
    endfunction

    assign ext32 = DATA_W'(req.pin_inputs);
    assign ext   = ext32[PIN_COUNT-1:0];
    assign wdata = req.write_data[PIN_COUNT-1:0];

    always_comb
    begin
        fsel_next  = fsel_reg;
        latch_next = latch_reg;
        if (req.action == ACT_WRITE) begin
            case (req.word_index)
                WORD_FSEL0: fsel_next[0] = req.write_data[FSEL_WIDTH-1:0] & fsel_mask(0);
                WORD_FSEL1: fsel_next[1] = req.write_data[FSEL_WIDTH-1:0] & fsel_mask(1);
                WORD_FSEL2: fsel_next[2] = req.write_data[FSEL_WIDTH-1:0] & fsel_mask(2);
                WORD_SET:   latch_next   = latch_reg | wdata;
                WORD_CLEAR: latch_next   = latch_reg & ~wdata;
                default:    ;
            endcase
        end
    end

    assign oe_now  = enables(fsel_reg);
    assign oe_next = enables(fsel_next);
    assign level   = (latch_reg & oe_now) | (ext & ~oe_now);

    always_comb
    begin
        rdata = '0;
        if (req.action == ACT_READ) begin
            case (req.word_index)
                WORD_FSEL0: rdata = DATA_W'(fsel_reg[0]);
                WORD_FSEL1: rdata = DATA_W'(fsel_reg[1]);
                WORD_FSEL2: rdata = DATA_W'(fsel_reg[2]);
                WORD_LEVEL: rdata = DATA_W'(level);
                default:    rdata = '0;
            endcase
        end
    end

    assign latch32 = DATA_W'(latch_next);
    assign oe32    = DATA_W'(oe_next);

    assign rsp.read_data         = rdata;
    assign rsp.pin_drive         = latch32[PORT_PINS-1:0];
    assign rsp.pin_output_enable = oe32[PORT_PINS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fsel_reg  <= '0;
            latch_reg <= '0;
        end else if (accept) begin
            fsel_reg  <= fsel_next;
            latch_reg <= latch_next;
        end
    end

endmodule

// ===== hw/rtl/gpio_pin_register_block_unit.sv =====
// ----------------------------------------------------------------------------
// GPIO pin register block - top level
// Word-addressed pin controller: function select, set/clear latch, levels.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one bus access per
//   transfer: action, word_index, write_data and the sampled pin_inputs.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one result per access:
//   read_data (zero for writes), plus pin_drive and pin_output_enable as
//   they stand after the access.
//   Result path: registered in the output slot, or in the skid slot when held.
//   Throughput: one access per cycle while req_stall is low; the decode and register
//   update are a single level of masks and muxes in front of the result register.
//   Stall: a result held by rsp_stall does not block the next request; it
//   lands in a one-entry skid buffer, and only when that buffer is full is
//   req_stall raised (it is a registered signal).
//   Reset: rst_n clears all function select codes (every pin an input), the
//   output latch and the valid flags of both result slots. There is no clearing pass.
// ----------------------------------------------------------------------------
`include "gpio_pin_register_block_unit_defines.svh"

module gpio_pin_register_block_unit #(
    parameter int PIN_COUNT = 28
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  gprb_pkg::gprb_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output gprb_pkg::gprb_rsp_t rsp
);
    import gprb_pkg::*;

    gprb_rsp_t result;
    gprb_rsp_t out_reg, out_next;
    gprb_rsp_t skid_reg, skid_next;
    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    logic      accept;
    logic      out_free;

    // a request transfers whenever the skid slot is empty
    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && !skid_valid_reg;

    gprb_regfile #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .rsp    (result)
    );

    // output slot frees up when empty or when its transfer completes
    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                // drain held result first; no request is taken this cycle
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else if (accept) begin
                out_next       = result;
                out_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (accept) begin
            // receiver stalled: park the new result
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload slots carry no reset
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // skid only fills behind a held output
    `GPRB_NEVER(a_skid_without_out, clk, rst_n, skid_valid_reg && !out_valid_reg)
    // an accepted request behind a stalled result must be parked
    `GPRB_ASSERT(a_park_on_stall, clk, rst_n, (out_valid_reg && rsp_stall && accept) |=> skid_valid_reg)
    // a parked result moves forward as soon as the output transfers
    `GPRB_ASSERT(a_skid_drain, clk, rst_n, (skid_valid_reg && !rsp_stall) |=> (out_valid_reg && !skid_valid_reg))
    // an accepted request always leaves the output valid next cycle
    `GPRB_ASSERT(a_result_follows, clk, rst_n, accept |=> out_valid_reg)

endmodule
